// ===== sv/address_hit_count_table_macros.svh =====
// Assertion macros shared by the hit count table RTL.
`ifndef ADDRESS_HIT_COUNT_TABLE_MACROS_SVH
`define ADDRESS_HIT_COUNT_TABLE_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define AHCT_CHECK(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (cond)) else $error(msg);

// A consequence that must hold in the same cycle as its antecedent.
`define AHCT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> (cons)) else $error(msg);

// A consequence that must hold in the cycle after its antecedent.
`define AHCT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/ahct_pkg.sv =====
// Types and constants of the address hit count table.
`timescale 1ns / 1ps
`default_nettype none

package ahct_pkg;

  localparam int unsigned ADDR_W  = 64;
  localparam int unsigned COUNT_W = 31;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef enum logic {
    FUNC_RECORD = 1'b0,
    FUNC_DUMP   = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_UPDATE,
    S_DUMP
  } state_e;

  typedef struct packed {
    logic              func;
    logic [ADDR_W-1:0] block_addr;
  } ahct_in_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  entry_addr;
    logic [COUNT_W-1:0] entry_count;
    logic               entry_valid;
    logic               table_overflowed;
    logic               last;
  } ahct_out_t;

  // Commands broadcast from the sequencer to every cell of the chain.
  typedef struct packed {
    logic capture;  // compare the key against the stored address
    logic update;   // bump the count of a cell that matched
    logic append;   // write the key into the cell at the fill position
    logic shift;    // take the entry of the next cell up the chain
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== sv/ahct_in_if.sv =====
// Request channel of the hit count table.
`timescale 1ns / 1ps
`default_nettype none

interface ahct_in_if;
  import ahct_pkg::*;

  logic     valid;
  logic     ready;
  ahct_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/ahct_out_if.sv =====
// Result channel of the hit count table.
`timescale 1ns / 1ps
`default_nettype none

interface ahct_out_if;
  import ahct_pkg::*;

  logic      valid;
  logic      ready;
  ahct_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/ahct_cell.sv =====
// One table entry: stored address, hit count and match flag.
`timescale 1ns / 1ps
`default_nettype none

module ahct_cell #(
  parameter int unsigned FILL_W = 7,
  parameter int unsigned IDX    = 0
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire ahct_pkg::cell_ctrl_t         ctrl_i,
  input  wire logic [FILL_W-1:0]            fill_i,
  input  wire logic [ahct_pkg::ADDR_W-1:0]  key_i,
  input  wire logic [ahct_pkg::ADDR_W-1:0]  nxt_addr_i,
  input  wire logic [ahct_pkg::COUNT_W-1:0] nxt_count_i,
  output logic      [ahct_pkg::ADDR_W-1:0]  addr_o,
  output logic      [ahct_pkg::COUNT_W-1:0] count_o,
  output logic                              hit_o
);
  import ahct_pkg::*;

  localparam logic [FILL_W-1:0] IDX_F = FILL_W'(IDX);

  logic [ADDR_W-1:0]  addr_q;
  logic [COUNT_W-1:0] count_q;
  logic               hit_q;
  logic               occupied;

  // Entries below the fill level are live; the rest are never looked at.
  assign occupied = (IDX_F < fill_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else if (ctrl_i.capture) begin
      hit_q <= occupied && (addr_q == key_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      addr_q  <= nxt_addr_i;
      count_q <= nxt_count_i;
    end else if (ctrl_i.update && hit_q) begin
      if (count_q != COUNT_MAX) begin
        count_q <= count_q + COUNT_W'(1);
      end
    end else if (ctrl_i.append && (fill_i == IDX_F)) begin
      addr_q  <= key_i;
      count_q <= COUNT_W'(1);
    end
  end

  assign addr_o  = addr_q;
  assign count_o = count_q;
  assign hit_o   = hit_q;

endmodule

`default_nettype wire

// ===== sv/address_hit_count_table.sv =====
// Top level of the address hit count table: sequencer, output register, cell chain.
//
//   channel | dir | payload                                          | handshake
//   in_i    | in  | func, block_addr                                 | valid/ready
//   out_o   | out | entry_addr, entry_count, entry_valid,            | valid/ready
//           |     | table_overflowed, last                           |
//
// A record request compares the address in every cell at once at the accept
// edge; S_UPDATE then bumps the matching count, or appends the address or flags overflow.
// A dump request yields one result per entry (at least one) and empties the
// table, as the chain shifts toward cell 0 by one entry for each result loaded.
// The output register lets the next request in while the last result waits;
// a stalled result channel holds the dump where it is.
// Reset clears the fill level, the overflow flag and the sequencer.
`timescale 1ns / 1ps
`default_nettype none
`include "address_hit_count_table_macros.svh"

module address_hit_count_table #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ahct_in_if.sink   in_i,
  ahct_out_if.source out_o
);
  import ahct_pkg::*;

  localparam int unsigned FILL_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [FILL_W-1:0] DEPTH_F = FILL_W'(TABLE_DEPTH);

  state_e              state_q, state_d;
  logic [FILL_W-1:0]   fill_q, fill_d;
  logic                ovf_q, ovf_d;
  logic [ADDR_W-1:0]   key_q;
  logic                out_valid_q, out_valid_d;
  ahct_out_t           out_q, out_d;

  cell_ctrl_t          ctrl;
  logic [ADDR_W-1:0]   key;
  logic                accept;
  logic                any_hit;
  logic                emit;

  logic [ADDR_W-1:0]      cell_addr [TABLE_DEPTH];
  logic [COUNT_W-1:0]     cell_count [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] hit_vec;

  assign in_i.ready = (state_q == S_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign any_hit    = |hit_vec;
  assign emit       = (state_q == S_DUMP) && (!out_valid_q || out_o.ready);

  // The key is the incoming address at capture and the held one afterwards.
  assign key = (state_q == S_IDLE) ? in_i.data.block_addr : key_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = (in_i.data.func == FUNC_DUMP) ? S_DUMP : S_UPDATE;
        end
      end
      S_UPDATE: state_d = S_IDLE;
      S_DUMP: begin
        if (emit && (fill_q <= FILL_W'(1))) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    ctrl        = '0;
    fill_d      = fill_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_d       = out_q;
    case (state_q)
      S_IDLE: begin
        ctrl.capture = accept && (in_i.data.func == FUNC_RECORD);
      end
      S_UPDATE: begin
        ctrl.update = 1'b1;
        if (!any_hit) begin
          if (fill_q < DEPTH_F) begin
            ctrl.append = 1'b1;
            fill_d      = fill_q + FILL_W'(1);
          end else begin
            ovf_d = 1'b1;
          end
        end
      end
      S_DUMP: begin
        if (emit) begin
          out_valid_d            = 1'b1;
          out_d.table_overflowed = ovf_q;
          out_d.last             = (fill_q <= FILL_W'(1));
          if (fill_q != '0) begin
            out_d.entry_addr  = cell_addr[0];
            out_d.entry_count = cell_count[0];
            out_d.entry_valid = 1'b1;
            ctrl.shift        = 1'b1;
            fill_d            = fill_q - FILL_W'(1);
          end else begin
            out_d.entry_addr  = '0;
            out_d.entry_count = '0;
            out_d.entry_valid = 1'b0;
          end
          if (fill_q <= FILL_W'(1)) begin
            ovf_d = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (accept) begin
      key_q <= in_i.data.block_addr;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    logic [ADDR_W-1:0]  nxt_addr;
    logic [COUNT_W-1:0] nxt_count;

    if (i == TABLE_DEPTH - 1) begin : g_end
      assign nxt_addr  = cell_addr[i];
      assign nxt_count = cell_count[i];
    end else begin : g_mid
      assign nxt_addr  = cell_addr[i+1];
      assign nxt_count = cell_count[i+1];
    end

    ahct_cell #(
      .FILL_W (FILL_W),
      .IDX    (i)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .fill_i      (fill_q),
      .key_i       (key),
      .nxt_addr_i  (nxt_addr),
      .nxt_count_i (nxt_count),
      .addr_o      (cell_addr[i]),
      .count_o     (cell_count[i]),
      .hit_o       (hit_vec[i])
    );
  end

  `AHCT_CHECK(a_fill_bound, fill_q <= DEPTH_F, "fill level beyond table depth")
  `AHCT_IMPLIES(a_single_hit, state_q == S_UPDATE, $onehot0(hit_vec), "address held twice")
  `AHCT_NEXT(a_record_update, ctrl.capture, state_q == S_UPDATE, "record skipped its update")
  `AHCT_NEXT(a_dump_clears, emit && out_d.last, (fill_q == '0) && !ovf_q, "dump left state")

endmodule

`default_nettype wire
